/* hdl/stream_pattern_replace_defines.svh */
// Assertion macros shared by the stream_pattern_replace verification files.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef STREAM_PATTERN_REPLACE_DEFINES_SVH
`define STREAM_PATTERN_REPLACE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stream_pattern_replace: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stream_pattern_replace: next-cycle check failed");

`endif

/* hdl/spr_pkg.sv */
// Shared types and constants of the stream pattern replacer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package spr_pkg;

	localparam int PATTERN_MAX = 8;
	localparam int REPLACE_MAX = 8;
	localparam int RESULT_MAX  = 8;
	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 4;
	localparam int WORD_W      = BYTE_W * RESULT_MAX;
	localparam int IDX_W       = $clog2(RESULT_MAX);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_PATTERN      = 3'd0;
	localparam logic [2:0] REG_PATTERN_LEN  = 3'd1;
	localparam logic [2:0] REG_REPLACE      = 3'd2;
	localparam logic [2:0] REG_REPLACE_LEN  = 3'd3;
	localparam logic [2:0] REG_DOUBLE_BYTE  = 3'd4;

	// Configuration as the front end sees it, lengths already clamped.
	typedef struct packed {
		logic [WORD_W-1:0] pattern;
		logic [LEN_W-1:0]  plen;
		logic [WORD_W-1:0] replace;
		logic [LEN_W-1:0]  rlen;
		logic              dbcs;
	} spr_cfg_t;

	// One command: up to eight bytes to emit, in order, plus the end mark.
	typedef struct packed {
		logic [WORD_W-1:0] bytes;
		logic [LEN_W-1:0]  count;
		logic              eos;
	} spr_cmd_t;

endpackage

`default_nettype wire

/* hdl/spr_front.sv */
// Front end: accepts input bytes, keeps the match window and turns each
// byte into at most one emit command. Depends on spr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spr_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire spr_pkg::spr_cfg_t cfg,
	input  wire                 plen_clear,
	input  wire                 data_valid,
	output logic                data_ready,
	input  wire  [7:0]          data_byte,
	input  wire                 last_byte,
	output logic                cmd_valid,
	input  wire                 cmd_ready,
	output spr_pkg::spr_cmd_t   cmd
);
	import spr_pkg::*;

	localparam logic [7:0] LEAD_LO_A = 8'h81;
	localparam logic [7:0] LEAD_HI_A = 8'h9F;
	localparam logic [7:0] LEAD_LO_B = 8'hE0;
	localparam logic [7:0] LEAD_HI_B = 8'hFC;

	function automatic logic is_lead(input logic [7:0] b);
		is_lead = (b >= LEAD_LO_A && b <= LEAD_HI_A) || (b >= LEAD_LO_B && b <= LEAD_HI_B);
	endfunction

	logic [WORD_W-1:0] win_q;
	logic [LEN_W-1:0]  fill_q;
	logic              trail_q;

	logic [WORD_W-1:0] win_ins;
	logic [WORD_W-1:0] win_nxt;
	logic [LEN_W-1:0]  fill_ins;
	logic [LEN_W-1:0]  fill_nxt;
	logic              trail_nxt;
	logic              full;
	logic              hit;
	logic              lead;
	logic              accept;

	assign data_ready = cmd_ready;
	assign accept     = data_valid && data_ready;

	always_comb begin
		win_ins = win_q;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (fill_q == LEN_W'(i)) begin
				win_ins[i*BYTE_W +: BYTE_W] = data_byte;
			end
		end
		fill_ins = fill_q + LEN_W'(1);
		full     = (fill_ins == cfg.plen);
		hit      = 1'b1;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (LEN_W'(i) < cfg.plen &&
				win_ins[i*BYTE_W +: BYTE_W] != cfg.pattern[i*BYTE_W +: BYTE_W]) begin
				hit = 1'b0;
			end
		end
		lead = cfg.dbcs && is_lead(win_ins[BYTE_W-1:0]);
	end

	always_comb begin
		cmd.eos   = last_byte;
		cmd.bytes = win_ins;
		cmd.count = '0;
		win_nxt   = win_ins;
		fill_nxt  = fill_ins;
		trail_nxt = 1'b0;
		if (trail_q) begin
			// Trail byte of a lone lead byte goes straight out, unmatched.
			cmd.bytes = {{(WORD_W-BYTE_W){1'b0}}, data_byte};
			cmd.count = LEN_W'(1);
			win_nxt   = win_q;
			fill_nxt  = fill_q;
		end else if (full && hit) begin
			cmd.bytes = cfg.replace;
			cmd.count = cfg.rlen;
			fill_nxt  = '0;
		end else if (full && lead) begin
			if (cfg.plen >= LEN_W'(2)) begin
				cmd.count = last_byte ? fill_ins : LEN_W'(2);
				win_nxt   = win_ins >> (2 * BYTE_W);
				fill_nxt  = fill_ins - LEN_W'(2);
			end else begin
				cmd.count = LEN_W'(1);
				fill_nxt  = '0;
				trail_nxt = 1'b1;
			end
		end else if (full) begin
			cmd.count = last_byte ? fill_ins : LEN_W'(1);
			win_nxt   = win_ins >> BYTE_W;
			fill_nxt  = fill_ins - LEN_W'(1);
		end else begin
			cmd.count = last_byte ? fill_ins : '0;
		end
		if (last_byte) begin
			fill_nxt  = '0;
			trail_nxt = 1'b0;
		end
	end

	assign cmd_valid = accept && (cmd.count != '0 || last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			trail_q <= 1'b0;
		end else if (plen_clear) begin
			fill_q  <= '0;
			trail_q <= 1'b0;
		end else if (accept) begin
			fill_q  <= fill_nxt;
			trail_q <= trail_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_q <= win_nxt;
		end
	end

endmodule

`default_nettype wire

/* hdl/spr_queue.sv */
// Short command queue between front and back end.
// Depends on spr_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module spr_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push_valid,
	output logic                push_ready,
	input  wire spr_pkg::spr_cmd_t push_cmd,
	output logic                pop_valid,
	input  wire                 pop_ready,
	output spr_pkg::spr_cmd_t   pop_cmd
);
	import spr_pkg::*;

	spr_cmd_t          ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = ent_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

/* hdl/spr_back.sv */
// Back end: walks the bytes of each command into a registered result beat.
// Depends on spr_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none

module spr_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cmd_valid,
	output logic                cmd_ready,
	input  wire spr_pkg::spr_cmd_t cmd,
	output logic                result_valid,
	input  wire                 result_ready,
	output logic [7:0]          out_byte,
	output logic                byte_valid,
	output logic                end_of_stream
);
	import spr_pkg::*;

	logic [IDX_W-1:0]  idx_q;
	logic [LEN_W-1:0]  idx_inc;
	logic              final_byte;
	logic              load;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              byte_valid_q;
	logic              eos_q;

	assign idx_inc    = LEN_W'(idx_q) + LEN_W'(1);
	assign final_byte = (idx_inc >= cmd.count);
	assign load       = cmd_valid && (!out_valid_q || result_ready);
	assign cmd_ready  = load && final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= final_byte ? '0 : idx_inc[IDX_W-1:0];
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_valid_q <= (cmd.count != '0);
			out_byte_q   <= (cmd.count != '0) ? cmd.bytes[{idx_q, 3'b000} +: BYTE_W] : '0;
			eos_q        <= cmd.eos && final_byte;
		end
	end

	assign result_valid  = out_valid_q;
	assign out_byte      = out_byte_q;
	assign byte_valid    = byte_valid_q;
	assign end_of_stream = eos_q;

endmodule

`default_nettype wire

/* hdl/stream_pattern_replace.sv */
// Top level of the stream pattern replacer: configuration registers and
// the front end, command queue and back end. Depends on spr_pkg.
//
// Usage: input beats (data_byte, last_byte) arrive on the data channel,
// result beats (out_byte, byte_valid, end_of_stream) leave on the result
// channel, both with valid/ready. Every leftmost, non-overlapping
// occurrence of the pattern is replaced by the replacement text; in
// double-byte mode a Shift_JIS lead byte leaves with its trail byte.
// Configuration goes through the APB port at byte address 8*index while
// the block is idle; writing pattern_length empties the match window.
// Path: the front end forms each command combinationally, the queue
// registers it and the back end registers the result beat from it.
// Throughput: one input beat per cycle and one result beat per cycle while
// neither channel stalls and the queue has room; a match whose replacement
// is longer than one byte takes one result beat per replacement byte, and
// the four-entry command queue between front and back end absorbs the burst.
// When the receiver stalls, the result register holds its beat, the queue
// fills and data_ready falls once it holds four commands.
// Reset empties the window, the queue and the result register and loads
// the register reset values (pattern length one, all else zero).
`timescale 1ns / 1ps
`default_nettype none

module stream_pattern_replace (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [5:0]  paddr,
	input  wire  [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  wire         data_valid,
	output logic        data_ready,
	input  wire  [7:0]  data_byte,
	input  wire         last_byte,
	output logic        result_valid,
	input  wire         result_ready,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        end_of_stream
);
	import spr_pkg::*;

	logic [WORD_W-1:0] pattern_q;
	logic [LEN_W-1:0]  plen_q;
	logic [WORD_W-1:0] replace_q;
	logic [LEN_W-1:0]  rlen_q;
	logic              dbcs_q;
	logic              wr_en;
	logic [2:0]        reg_idx;
	logic              plen_clear;
	spr_cfg_t          cfg;

	spr_cmd_t          push_cmd;
	logic              push_valid;
	logic              push_ready;
	spr_cmd_t          pop_cmd;
	logic              pop_valid;
	logic              pop_ready;

	assign pready     = 1'b1;
	assign reg_idx    = paddr[5:3];
	assign wr_en      = psel && penable && pwrite && pready;
	assign plen_clear = wr_en && (reg_idx == REG_PATTERN_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= LEN_W'(1);
			replace_q <= '0;
			rlen_q    <= '0;
			dbcs_q    <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PATTERN:     pattern_q <= pwdata;
				REG_PATTERN_LEN: plen_q    <= pwdata[LEN_W-1:0];
				REG_REPLACE:     replace_q <= pwdata;
				REG_REPLACE_LEN: rlen_q    <= pwdata[LEN_W-1:0];
				REG_DOUBLE_BYTE: dbcs_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PATTERN:     prdata = pattern_q;
			REG_PATTERN_LEN: prdata = {{(64-LEN_W){1'b0}}, plen_q};
			REG_REPLACE:     prdata = replace_q;
			REG_REPLACE_LEN: prdata = {{(64-LEN_W){1'b0}}, rlen_q};
			REG_DOUBLE_BYTE: prdata = {63'd0, dbcs_q};
			default:         prdata = '0;
		endcase
	end

	// Clamp the lengths: a zero pattern length acts as one, larger values
	// saturate at the maximum.
	always_comb begin
		cfg.pattern = pattern_q;
		cfg.replace = replace_q;
		cfg.dbcs    = dbcs_q;
		if (plen_q == '0) begin
			cfg.plen = LEN_W'(1);
		end else if (plen_q > LEN_W'(PATTERN_MAX)) begin
			cfg.plen = LEN_W'(PATTERN_MAX);
		end else begin
			cfg.plen = plen_q;
		end
		if (rlen_q > LEN_W'(REPLACE_MAX)) begin
			cfg.rlen = LEN_W'(REPLACE_MAX);
		end else begin
			cfg.rlen = rlen_q;
		end
	end

	spr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.plen_clear (plen_clear),
		.data_valid (data_valid),
		.data_ready (data_ready),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.cmd_valid  (push_valid),
		.cmd_ready  (push_ready),
		.cmd        (push_cmd)
	);

	spr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	spr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (pop_valid),
		.cmd_ready     (pop_ready),
		.cmd           (pop_cmd),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.end_of_stream (end_of_stream)
	);

endmodule

`default_nettype wire

/* hdl/spr_checker.sv */
// Port-level checks of stream_pattern_replace, bound to the top level.
// Depends on stream_pattern_replace_defines.svh for the assertion macros and on spr_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "stream_pattern_replace_defines.svh"

module spr_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        psel,
	input wire        penable,
	input wire        pwrite,
	input wire [5:0]  paddr,
	input wire [63:0] pwdata,
	input wire [63:0] prdata,
	input wire        pready,
	input wire        data_valid,
	input wire        data_ready,
	input wire [7:0]  data_byte,
	input wire        last_byte,
	input wire        result_valid,
	input wire        result_ready,
	input wire [7:0]  out_byte,
	input wire        byte_valid,
	input wire        end_of_stream
);
	import spr_pkg::*;

	// A beat without data is only ever the pure end marker.
	`SPR_ASSERT_SAME(a_pure_end_marker, clk, arst_n, result_valid && !byte_valid, end_of_stream && out_byte == 8'd0)

	// A stalled result beat holds its payload.
	`SPR_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(out_byte) && $stable(byte_valid) && $stable(end_of_stream))

	// A stalled input beat holds its payload.
	`SPR_ASSERT_NEXT(a_data_hold, clk, arst_n, data_valid && !data_ready, data_valid && $stable(data_byte) && $stable(last_byte))

	// The pattern length register reads back only its four stored bits.
	`SPR_ASSERT_SAME(a_plen_read_width, clk, arst_n, psel && paddr[5:3] == REG_PATTERN_LEN, prdata[63:4] == 60'd0)

	// A pattern length write is visible on the next read of that register.
	`SPR_ASSERT_NEXT(a_plen_readback, clk, arst_n, psel && penable && pwrite && pready && paddr[5:3] == REG_PATTERN_LEN, !psel || paddr[5:3] != REG_PATTERN_LEN || prdata[3:0] == $past(pwdata[3:0]))

endmodule

bind stream_pattern_replace spr_checker u_spr_checker (.*);

`default_nettype wire
